/* rtl/core/spc_pkg.sv */
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the semiprime classifier.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int CAND_W     = 16;
  localparam int IN_DATA_W  = 16;
  localparam int SF_W       = 8;
  localparam int LF_W       = 15;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } spc_div_stat_t;

endpackage

/* rtl/core/spc_div.sv */
// ----------------------------------------------------------------------------
// spc_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spc_div #(
  parameter int W  = 16,
  parameter int DW = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [W-1:0]          dividend_i,
  input  logic [DW-1:0]         divisor_i,
  output spc_pkg::spc_div_stat_t stat_o,
  output logic [W-1:0]          quotient_o
);
  import spc_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  shift_q, shift_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, shift_q[W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CW'(W);
      shift_d = dividend_i;
      rem_d   = '0;
      dvs_d   = divisor_i;
    end else if (busy_q) begin
      shift_d = {shift_q[W-2:0], ge};
      rem_d   = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);
  assign quotient_o      = shift_q;

endmodule

/* rtl/core/semiprime_classifier.sv */
// ----------------------------------------------------------------------------
// semiprime_classifier
// Trial-division semiprime test with a per-range "any found" flag.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                                  | tlast
//  s_axis   | in        | candidate[15:0]                        | last_in_range
//  m_axis   | out       | is_semiprime, smaller_factor,          | range_done
//           |           | larger_factor, range_had_any           |
//
//  Each trial divisor takes one pass through the bit-serial divider; the trials
//  run up to sqrt(candidate) for the factor search plus up to sqrt(cofactor)
//  for the cofactor primality check.
//  One request is worked on at a time; s_axis is ready only when idle.
//  The finished result sits in the output register, so a new request is
//  taken while it waits; completion stalls only if that register is full.
//  Reset clears control state and the range flag; there is no clearing pass.
// ----------------------------------------------------------------------------
module semiprime_classifier #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] candidate
  input  logic [spc_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] is_semiprime, [8:1] smaller_factor, [23:9] larger_factor,
  // [24] range_had_any, [31:25] zero
  output logic [spc_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);
  import spc_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int DW  = (W + 1) / 2 + 1;
  localparam int SQW = W + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [W-1:0]   n_q, n_d;
  logic           last_q, last_d;
  logic [DW-1:0]  d_q, d_d;
  logic [DW-1:0]  p_q, p_d;
  logic [SQW-1:0] sq_q, sq_d;
  logic [W-1:0]   q_q, q_d;
  logic           semi_q, semi_d;
  logic           found_q, found_d;

  logic           out_valid_q, out_valid_d;
  logic           out_semi_q, out_semi_d;
  logic [SF_W-1:0] out_p_q, out_p_d;
  logic [LF_W-1:0] out_q_q, out_q_d;
  logic           out_any_q, out_any_d;
  logic           out_last_q, out_last_d;

  logic [W+CAND_W-1:0] cand_wide;
  logic [DW+SF_W-1:0]  p_wide;
  logic [W+LF_W-1:0]   q_wide;
  logic [W-1:0]        target;
  logic                sq_le;
  logic                div_start;
  logic                load;
  logic                in_acc;
  logic [W-1:0]        quotient;
  spc_div_stat_t       div_stat;

  assign cand_wide = (W + CAND_W)'(s_axis_tdata_i[CAND_W-1:0]);
  assign p_wide    = (DW + SF_W)'(p_q);
  assign q_wide    = (W + LF_W)'(q_q);
  assign target    = (state_q == ST_CHK) ? q_q : n_q;
  assign sq_le     = (sq_q <= SQW'(target));
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready_i);

  spc_div #(
    .W  (W),
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (target),
    .divisor_i  (d_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    last_d    = last_q;
    d_d       = d_q;
    p_d       = p_q;
    sq_d      = sq_q;
    q_d       = q_q;
    semi_d    = semi_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d     = cand_wide[W-1:0];
          last_d  = s_axis_tlast_i;
          d_d     = DW'(2);
          sq_d    = SQW'(4);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sq_le) begin
          div_start = 1'b1;
          state_d   = ST_DIV1;
        end else begin
          semi_d  = 1'b0;
          state_d = ST_FIN;
        end
      end
      ST_DIV1: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            q_d     = quotient;
            p_d     = d_q;
            state_d = ST_CHK;
          end else begin
            d_d     = d_q + 1'b1;
            sq_d    = sq_q + SQW'({d_q, 1'b1});
            state_d = ST_SCAN;
          end
        end
      end
      ST_CHK: begin
        if (sq_le) begin
          div_start = 1'b1;
          state_d   = ST_DIV2;
        end else begin
          semi_d  = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_DIV2: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            semi_d  = 1'b0;
            state_d = ST_FIN;
          end else begin
            d_d     = d_q + 1'b1;
            sq_d    = sq_q + SQW'({d_q, 1'b1});
            state_d = ST_CHK;
          end
        end
      end
      ST_FIN: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_semi_d  = out_semi_q;
    out_p_d     = out_p_q;
    out_q_d     = out_q_q;
    out_any_d   = out_any_q;
    out_last_d  = out_last_q;
    found_d     = found_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_semi_d  = semi_q;
      out_p_d     = semi_q ? p_wide[SF_W-1:0] : '0;
      out_q_d     = semi_q ? q_wide[LF_W-1:0] : '0;
      out_any_d   = found_q | semi_q;
      out_last_d  = last_q;
      found_d     = last_q ? 1'b0 : (found_q | semi_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    last_q     <= last_d;
    d_q        <= d_d;
    p_q        <= p_d;
    sq_q       <= sq_d;
    q_q        <= q_d;
    semi_q     <= semi_d;
    out_semi_q <= out_semi_d;
    out_p_q    <= out_p_d;
    out_q_q    <= out_q_d;
    out_any_q  <= out_any_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_any_q, out_q_q, out_p_q, out_semi_q});
  assign m_axis_tlast_o  = out_last_q;

  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
    else $error("divider finished outside a wait state");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_zero_factors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_semi_q) |-> (out_p_q == '0 && out_q_q == '0))
    else $error("factors reported for a non-semiprime");

  a_range_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_q) |=> !found_q)
    else $error("range flag kept past the last item");

endmodule
